// ===== rtl/ldr2_pkg.sv =====
package ldr2_pkg;

   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = 16;

   localparam int DATA_BITS  = 32;
   localparam int USED_BITS  = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
   localparam int PC_BITS    = $clog2(USED_BITS + 1);
   localparam int PC_LEVELS  = $clog2(USED_BITS);
   localparam int PC_SIZE    = 1 << PC_LEVELS;

   localparam int N_BITS     = 16;
   localparam int CMP_BITS   = (COUNT_BITS > N_BITS) ? COUNT_BITS : N_BITS;
   localparam int PROD_BITS  = 2 * N_BITS;
   localparam int WIDE_BITS  = 2 * PROD_BITS;

   localparam int SCORE_BITS     = 17;
   localparam int QUO_STEPS      = 16;
   localparam int STEP_BITS      = $clog2(QUO_STEPS);
   localparam int REQ_DATA_BITS  = 2 * DATA_BITS;
   localparam int RSP_DATA_BITS  = 24;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [N_BITS-1:0]     SAMPLE_COUNT_RESET = N_BITS'(10000);
   localparam logic [SCORE_BITS-1:0] Q16_ONE            = SCORE_BITS'(65536);

   typedef struct packed {
      logic [COUNT_BITS-1:0] ones_a;
      logic [COUNT_BITS-1:0] ones_b;
      logic [COUNT_BITS-1:0] ones_both;
      logic [N_BITS-1:0]     sample_count;
   } entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PROD,
      BK_SQUARE,
      BK_CHECK,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

   function automatic logic [PC_BITS-1:0] pop_count(input logic [USED_BITS-1:0] w);
      logic [PC_SIZE-1:0] wp;
      logic [PC_BITS-1:0] t [PC_SIZE];
      wp = PC_SIZE'(w);
      for (int i = 0; i < PC_SIZE; i++) begin
         t[i] = PC_BITS'(wp[i]);
      end
      for (int lvl = 0; lvl < PC_LEVELS; lvl++) begin
         for (int i = 0; i < (PC_SIZE >> (lvl + 1)); i++) begin
            t[i] = t[2*i] + t[2*i+1];
         end
      end
      return t[0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] acc,
                                                     input logic [PC_BITS-1:0] inc);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, acc} + (COUNT_BITS+1)'(inc);
      return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/ldr2_front.sv =====
module ldr2_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [ldr2_pkg::DATA_BITS-1:0] word_a,
   input  logic [ldr2_pkg::DATA_BITS-1:0] word_b,
   input  logic                        last_word,
   input  logic [ldr2_pkg::N_BITS-1:0] sample_count,
   output logic                        push,
   output ldr2_pkg::entry_type         push_entry
);
   import ldr2_pkg::*;

   logic [COUNT_BITS-1:0] ones_a_ff, ones_b_ff, ones_both_ff;
   logic [COUNT_BITS-1:0] ones_a_in, ones_b_in, ones_both_in;
   logic [COUNT_BITS-1:0] sum_a, sum_b, sum_both;

   always_comb begin
      sum_a    = sat_add(ones_a_ff, pop_count(word_a[USED_BITS-1:0]));
      sum_b    = sat_add(ones_b_ff, pop_count(word_b[USED_BITS-1:0]));
      sum_both = sat_add(ones_both_ff,
                         pop_count(word_a[USED_BITS-1:0] & word_b[USED_BITS-1:0]));
      ones_a_in    = ones_a_ff;
      ones_b_in    = ones_b_ff;
      ones_both_in = ones_both_ff;
      if (accept) begin
         if (last_word) begin
            ones_a_in    = '0;
            ones_b_in    = '0;
            ones_both_in = '0;
         end else begin
            ones_a_in    = sum_a;
            ones_b_in    = sum_b;
            ones_both_in = sum_both;
         end
      end
   end

   assign push                    = accept && last_word;
   assign push_entry.ones_a       = sum_a;
   assign push_entry.ones_b       = sum_b;
   assign push_entry.ones_both    = sum_both;
   assign push_entry.sample_count = sample_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_a_ff    <= '0;
         ones_b_ff    <= '0;
         ones_both_ff <= '0;
      end else begin
         ones_a_ff    <= ones_a_in;
         ones_b_ff    <= ones_b_in;
         ones_both_ff <= ones_both_in;
      end
   end

endmodule

// ===== rtl/ldr2_queue.sv =====
module ldr2_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldr2_pkg::entry_type push_entry,
   input  logic                pop,
   output ldr2_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);
   import ldr2_pkg::*;

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/ldr2_back.sv =====
module ldr2_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ldr2_pkg::entry_type             head_entry,
   input  logic                            empty,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ldr2_pkg::SCORE_BITS-1:0] rsp_score,
   output logic                            rsp_mono
);
   import ldr2_pkg::*;

   back_state_type state_ff, state_in;

   logic [N_BITS-1:0]     n_ff, c1_ff, c2_ff, c11_ff;
   logic                  deg_ff;
   logic [PROD_BITS-1:0]  p_ff, s_ff, t_ff;
   logic [WIDE_BITS-1:0]  num_ff, den_ff, rem_ff;
   logic [SCORE_BITS-1:0] quo_ff;
   logic                  mono_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  out_valid_ff;
   logic [SCORE_BITS-1:0] out_score_ff;
   logic                  out_mono_ff;

   logic                  load_out;
   logic [CMP_BITS-1:0]   n_x, c1_x, c2_x;
   logic                  deg_in;
   logic [PROD_BITS-1:0]  mag;
   logic [WIDE_BITS:0]    shifted;
   logic                  take;
   logic [WIDE_BITS-1:0]  rem_in;

   always_comb begin
      n_x    = CMP_BITS'(head_entry.sample_count);
      c1_x   = CMP_BITS'(head_entry.ones_a);
      c2_x   = CMP_BITS'(head_entry.ones_b);
      deg_in = (c1_x == '0) || (c2_x == '0) || (c1_x >= n_x) || (c2_x >= n_x);
      mag    = (p_ff >= s_ff) ? (p_ff - s_ff) : (s_ff - p_ff);
      shifted = {rem_ff, 1'b0};
      take    = shifted[WIDE_BITS] || (shifted[WIDE_BITS-1:0] >= den_ff);
      rem_in  = take ? (shifted[WIDE_BITS-1:0] - den_ff) : shifted[WIDE_BITS-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!empty) state_in = BK_PROD;
         BK_PROD:   state_in = deg_ff ? BK_EMIT : BK_SQUARE;
         BK_SQUARE: state_in = BK_CHECK;
         BK_CHECK:  state_in = (num_ff >= den_ff) ? BK_EMIT : BK_DIVIDE;
         BK_DIVIDE: if (step_ff == STEP_BITS'(QUO_STEPS - 1)) state_in = BK_EMIT;
         BK_EMIT:   if (!out_valid_ff || rsp_ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop      = !empty;
         BK_EMIT: load_out = !out_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            n_ff   <= head_entry.sample_count;
            c1_ff  <= N_BITS'(head_entry.ones_a);
            c2_ff  <= N_BITS'(head_entry.ones_b);
            c11_ff <= N_BITS'(head_entry.ones_both);
            deg_ff <= deg_in;
         end
         BK_PROD: begin
            p_ff    <= PROD_BITS'(n_ff) * PROD_BITS'(c11_ff);
            s_ff    <= PROD_BITS'(c1_ff) * PROD_BITS'(c2_ff);
            t_ff    <= PROD_BITS'(n_ff - c1_ff) * PROD_BITS'(n_ff - c2_ff);
            quo_ff  <= '0;
            mono_ff <= deg_ff;
         end
         BK_SQUARE: begin
            num_ff <= WIDE_BITS'(mag) * WIDE_BITS'(mag);
            den_ff <= WIDE_BITS'(s_ff) * WIDE_BITS'(t_ff);
         end
         BK_CHECK: begin
            rem_ff  <= num_ff;
            step_ff <= '0;
            quo_ff  <= (num_ff >= den_ff) ? Q16_ONE : '0;
         end
         BK_DIVIDE: begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[SCORE_BITS-2:0], take};
            step_ff <= step_ff + 1'b1;
         end
         default: ;
      endcase
      if (load_out) begin
         out_score_ff <= quo_ff;
         out_mono_ff  <= mono_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_score = out_score_ff;
   assign rsp_mono  = out_mono_ff;

endmodule

// ===== rtl/ld_r_squared_popcount.sv =====
// channel  | ports                          | contents
// ---------+--------------------------------+---------------------------------------
// request  | req_tvalid/tready/tdata/tlast  | tdata: word_a, word_b; tlast: last_word
// response | rsp_tvalid/tready/tdata/tuser  | tdata: ld_score; tuser: monomorphic
// csr      | csr_valid/ready/data           | sample_count
//
// the front takes one word pair per cycle and adds its popcounts in that cycle
// a last word moves the three counts into a two-entry queue for the back end
// the back end steps a pair through product, square, check, a 16-step shift-subtract
// divide and emit; saturation skips the divide, a monomorphic pair goes to emit after
// product; emit may wait on rsp_tready; the front stalls only when the queue is full
// reset clears counters, queue, back end and response valid; sample_count returns to 10000
module ld_r_squared_popcount (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // word_a[31:0], word_b[63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // ld_score[16:0], zero [23:17]
   output logic [0:0]  rsp_tuser,   // monomorphic[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import ldr2_pkg::*;

   logic [N_BITS-1:0]     sample_count_ff;
   logic                  req_accept;
   logic                  push, pop, full, empty;
   entry_type             push_entry, head_entry;
   logic [SCORE_BITS-1:0] score;
   logic                  mono;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         sample_count_ff <= csr_data;
      end
   end

   ldr2_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .word_a       (req_tdata[DATA_BITS-1:0]),
      .word_b       (req_tdata[REQ_DATA_BITS-1:DATA_BITS]),
      .last_word    (req_tlast),
      .sample_count (sample_count_ff),
      .push         (push),
      .push_entry   (push_entry)
   );

   ldr2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (full),
      .empty      (empty)
   );

   ldr2_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_score  (score),
      .rsp_mono   (mono)
   );

   assign rsp_tdata = RSP_DATA_BITS'(score);
   assign rsp_tuser = mono;

   a_mono_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[SCORE_BITS-1:0] == '0)
      else $error("monomorphic response with nonzero score");

   a_score_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SCORE_BITS-1:0] <= Q16_ONE)
      else $error("score above 1.0");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");

endmodule

// ===== dv/ld_r_squared_popcount_checker.sv =====
`timescale 1ns / 1ps
module ld_r_squared_popcount_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          pending,
   output int          failures
);
   import ldr2_pkg::*;

   localparam logic [N_BITS-1:0]     SAMPLES_AT_RESET = 16'd10000;
   localparam logic [SCORE_BITS-1:0] SCORE_ONE        = 17'h10000;
   localparam longint unsigned       COUNT_MAX        = (64'd1 << COUNT_BITS) - 1;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic                  mono;
   } ld_result_type;

   ld_result_type         score_q[$];
   logic [COUNT_BITS-1:0] count_a;
   logic [COUNT_BITS-1:0] count_b;
   logic [COUNT_BITS-1:0] count_ab;
   logic [N_BITS-1:0]     samples;

   // saturating add of the ones in the counted part of a word
   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] acc,
                                                  input logic [31:0] w);
      longint unsigned sum;
      sum = acc + $countones(w[USED_BITS-1:0]);
      return (sum > COUNT_MAX) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
   endfunction

   function automatic ld_result_type r2_score(input logic [N_BITS-1:0] n_in,
                                              input logic [COUNT_BITS-1:0] c1_in,
                                              input logic [COUNT_BITS-1:0] c2_in,
                                              input logic [COUNT_BITS-1:0] c11_in);
      longint unsigned n, c1, c2, c11, p, s, mag, num, den;
      logic [127:0]    quot;
      ld_result_type   r;
      n   = n_in;
      c1  = c1_in;
      c2  = c2_in;
      c11 = c11_in;
      r.score = '0;
      r.mono  = 1'b1;
      if (c1 == 0 || c2 == 0 || c1 >= n || c2 >= n) begin
         return r;
      end
      r.mono = 1'b0;
      p   = n * c11;
      s   = c1 * c2;
      mag = (p >= s) ? p - s : s - p;
      num = mag * mag;
      den = c1 * c2 * (n - c1) * (n - c2);
      if (num >= den) begin
         r.score = SCORE_ONE;
      end else begin
         quot    = ({64'd0, num} << 16) / {64'd0, den};
         r.score = quot[SCORE_BITS-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      int            errs;
      logic [31:0]   word_a;
      logic [31:0]   word_b;
      ld_result_type want;
      errs = 0;
      if (reset) begin
         score_q.delete();
         count_a  = '0;
         count_b  = '0;
         count_ab = '0;
         samples  = SAMPLES_AT_RESET;
         pending  <= 0;
         failures <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            samples = csr_data;
         end
         if (req_tvalid && req_tready) begin
            word_a   = req_tdata[31:0];
            word_b   = req_tdata[63:32];
            count_a  = bump(count_a, word_a);
            count_b  = bump(count_b, word_b);
            count_ab = bump(count_ab, word_a & word_b);
            if (req_tlast) begin
               score_q.push_back(r2_score(samples, count_a, count_b, count_ab));
               count_a  = '0;
               count_b  = '0;
               count_ab = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (score_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, got ld_score %0d monomorphic %0d",
                        $time, rsp_tdata[SCORE_BITS-1:0], rsp_tuser[0]);
               errs++;
            end else begin
               want = score_q.pop_front();
               if (rsp_tdata[SCORE_BITS-1:0] !== want.score) begin
                  $display("%0t: ld_score expected %0d got %0d",
                           $time, want.score, rsp_tdata[SCORE_BITS-1:0]);
                  errs++;
               end
               if (rsp_tdata[23:SCORE_BITS] !== '0) begin
                  $display("%0t: tdata padding expected 0 got %0h",
                           $time, rsp_tdata[23:SCORE_BITS]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.mono) begin
                  $display("%0t: monomorphic expected %0d got %0d",
                           $time, want.mono, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         pending  <= score_q.size();
         failures <= failures + errs;
      end
   end

endmodule

// ===== dv/ld_r_squared_popcount_tb.sv =====
`timescale 1ns / 1ps
module ld_r_squared_popcount_tb;
   import ldr2_pkg::*;

   localparam int LIGHT_IDLE = 31;
   localparam int HEAVY_IDLE = 71;
   localparam int PHASES     = 7;

   typedef enum int {
      WK_ZERO,
      WK_ONES,
      WK_FULL,
      WK_SPARSE,
      WK_SINGLE,
      WK_HALF
   } word_kind_type;

   typedef enum int {
      BR_INDEPENDENT,
      BR_SAME,
      BR_INVERSE,
      BR_NEAR,
      BR_SUBSET
   } pair_relation_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   int pending;
   int failures;
   int send_idle_pct = LIGHT_IDLE;
   int recv_idle_pct = HEAVY_IDLE;
   int words_sent    = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ld_r_squared_popcount u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ld_r_squared_popcount_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pending    (pending),
      .failures   (failures)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [31:0] pick_word(input word_kind_type kind);
      case (kind)
         WK_ZERO:   return '0;
         WK_ONES:   return '1;
         WK_FULL:   return $urandom;
         WK_SPARSE: return $urandom & $urandom & $urandom;
         WK_SINGLE: return 32'h1 << $urandom_range(31);
         default:   return $urandom & $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [31:0] a, input logic [31:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // pair length and density follow the sample count so most pairs stay polymorphic
   task automatic send_pair(input int n);
      int                kmax;
      int                k;
      word_kind_type     kind;
      pair_relation_type rel;
      logic [31:0]       a;
      logic [31:0]       b;
      kmax = n / 24;
      if (kmax < 1) kmax = 1;
      if (kmax > 24) kmax = 24;
      k    = $urandom_range(1, kmax);
      kind = word_kind_type'($urandom_range(WK_HALF));
      if (n < 64 && $urandom_range(1)) kind = WK_SPARSE;
      rel  = pair_relation_type'($urandom_range(BR_SUBSET));
      for (int i = 0; i < k; i++) begin
         a = pick_word(kind);
         case (rel)
            BR_SAME:    b = a;
            BR_INVERSE: b = ~a;
            BR_NEAR:    b = a ^ pick_word(WK_SINGLE);
            BR_SUBSET:  b = a & $urandom;
            default:    b = pick_word(word_kind_type'($urandom_range(WK_HALF)));
         endcase
         send_word(a, b, i == k - 1);
      end
   endtask

   task automatic write_samples(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_scores_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int n_list [PHASES];
      int budget [PHASES];
      int base;
      int n_now;
      n_list = '{65535, 37, 1, 0, 500, 10000, 2};
      budget = '{340, 340, 60, 60, 340, 340, 320};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pairs at the reset sample count
      send_word(32'h0, 32'hffffffff, 1'b1);
      send_word(32'hffffffff, 32'h0, 1'b1);
      send_word(32'hffffffff, 32'hffffffff, 1'b1);
      send_word(32'hffffffff, 32'h0000ffff, 1'b1);
      send_word(32'h0000ffff, 32'hffff0000, 1'b1);
      send_word(32'h55555555, 32'haaaaaaaa, 1'b0);
      send_word(32'hffffffff, 32'hffffffff, 1'b0);
      send_word(32'h80000000, 32'h00000001, 1'b1);
      send_word(32'h00000001, 32'h80000001, 1'b1);
      send_word(32'h0, 32'h0, 1'b0);
      send_word(32'hf0000000, 32'hf000000f, 1'b1);
      send_word(32'h0f0f0f0f, 32'h00ff00ff, 1'b1);
      for (int i = 0; i < 3; i++) begin
         send_word($urandom, $urandom, i == 2);
      end
      wait_scores_done();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 2) begin
            send_idle_pct = HEAVY_IDLE;
            recv_idle_pct = LIGHT_IDLE;
         end
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n_now = (ph == PHASES - 1) ? int'($urandom_range(2, 65535)) : n_list[ph];
         write_samples(n_now[15:0]);
         base = words_sent;
         while (words_sent - base < budget[ph]) send_pair(n_now);
         wait_scores_done();
      end

      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
